### rtl/tap_tempo_period_averager_assert.svh
// ---------------------------------------------------------------------------
// Tap tempo period averager: assertion macros
// Shared concurrent assertion forms; clk and rst_n come from the using module.
// ---------------------------------------------------------------------------
`ifndef TAP_TEMPO_PERIOD_AVERAGER_ASSERT_SVH
`define TAP_TEMPO_PERIOD_AVERAGER_ASSERT_SVH

// Same-cycle implication
`define TTPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TTPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ttpa_pkg.sv
// ---------------------------------------------------------------------------
// ttpa_pkg
// Shared types and constants of the tap tempo period averager.
// ---------------------------------------------------------------------------
`default_nettype none

package ttpa_pkg;

    // Default history length (intervals averaged at most)
    localparam int MAX_AVG_DEF = 64;

    // Field widths
    localparam int TAP_W       = 32;
    localparam int PERIOD_W    = 16;
    localparam int AVG_LEN_W   = 7;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;

    // Output beat layout
    localparam int OUT_FIELDS_W = PERIOD_W + 1 + TAP_W + 1 + TAP_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [AVG_LEN_W-1:0] AVG_LEN_RST = 7'd1;
    localparam logic [PERIOD_W-1:0]  MBP_RST     = 16'd2500;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_AVG_LEN         = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_BEAT_PERIOD = 1'b1;

    // Divider: one quotient bit per step, mean always fits PERIOD_W bits
    localparam int DIV_STEPS = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } ttpa_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic walk;
        logic div_step;
        logic load_out;
    } ttpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_done;
        logic div_done;
    } ttpa_status_t;

endpackage

`default_nettype wire

### rtl/ttpa_ctrl.sv
// ---------------------------------------------------------------------------
// ttpa_ctrl
// Sequencer: accept a tap, walk the history, divide, hand off the result.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tap_tempo_period_averager_assert.svh"

module ttpa_ctrl
    import ttpa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire ttpa_status_t st,
    output ttpa_cmd_t         cmd
);

    ttpa_state_t state_reg;
    ttpa_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (st.walk_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    `TTPA_ASSERT_IMPL(a_load_free, cmd.load_out, (!out_valid_reg || m_tready), "result overwritten")
    `TTPA_ASSERT_NEXT(a_one_item, (s_tvalid && s_tready), !s_tready, "second tap taken while busy")
    `TTPA_ASSERT_NEXT(a_load_shows, cmd.load_out, m_tvalid, "loaded result not presented")

endmodule

`default_nettype wire

### rtl/ttpa_dp.sv
// ---------------------------------------------------------------------------
// ttpa_dp
// History ring, interval walk, serial divider, config and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tap_tempo_period_averager_assert.svh"

module ttpa_dp
    import ttpa_pkg::*;
#(
    parameter int MAX_AVG = MAX_AVG_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ttpa_cmd_t             cmd,
    output ttpa_status_t               st,
    input  wire logic [TAP_W-1:0]      tap_time,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic [OUT_TDATA_W-1:0]     out_tdata
);

    localparam int DEPTH = MAX_AVG + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CNT_W = $clog2(MAX_AVG + 1);
    localparam int SUM_W = PERIOD_W + CNT_W;
    localparam int CMP_W = (CNT_W > AVG_LEN_W) ? CNT_W : AVG_LEN_W;

    // Config registers
    logic [AVG_LEN_W-1:0] avg_len_reg;
    logic [PERIOD_W-1:0]  mbp_reg;

    // History ring
    logic [TAP_W-1:0] hist_mem [DEPTH];
    logic [TAP_W-1:0] rd_data_reg;
    logic [AW-1:0]    newest_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [FW-1:0]    fill_reg;
    logic [AW-1:0]    slot_next;
    logic [AW-1:0]    rd_ptr_dec;

    // Walk state
    logic [TAP_W-1:0] tap_reg;
    logic [TAP_W-1:0] newer_reg;
    logic [CNT_W-1:0] age_reg;
    logic [CNT_W-1:0] walk_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [TAP_W-1:0] last_reg;
    logic             running_reg;

    logic [CMP_W-1:0] avg_len_ext;
    logic [CNT_W-1:0] walk_sat;
    logic [TAP_W-1:0] older;
    logic [TAP_W-1:0] diff;
    logic [TAP_W-1:0] last_calc;
    logic             step_ok;
    logic             walk_done;
    logic             first_step;

    // Divider
    logic [CNT_W-1:0]     rem_reg;
    logic [PERIOD_W-1:0]  quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_sub;
    logic                 fits;
    logic [CNT_W-1:0]     rem_next;

    // Result registers
    logic [PERIOD_W-1:0] avg_out_reg;
    logic                pvalid_out_reg;
    logic [TAP_W-1:0]    last_out_reg;
    logic                running_out_reg;
    logic [TAP_W-1:0]    next_out_reg;
    logic [PERIOD_W-1:0] avg_final;

    // Ring pointers
    assign slot_next  = (newest_reg == AW'(DEPTH - 1)) ? '0 : newest_reg + AW'(1);
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? AW'(DEPTH - 1) : rd_ptr_reg - AW'(1);

    // Walk length saturates at the history size
    assign avg_len_ext = CMP_W'(avg_len_reg);
    assign walk_sat    = (avg_len_ext > CMP_W'(MAX_AVG)) ? CNT_W'(MAX_AVG)
                                                         : CNT_W'(avg_len_ext);

    // One interval check per cycle; never-written slots read as zero
    always_comb
    begin
        older      = (FW'(age_reg) < fill_reg) ? rd_data_reg : '0;
        diff       = newer_reg - older;
        step_ok    = (age_reg <= walk_reg) && (older != '0)
                     && (diff <= TAP_W'(mbp_reg));
        walk_done  = !step_ok || (age_reg == walk_reg);
        first_step = (age_reg == CNT_W'(1));
        last_calc  = tap_reg - older;
        sum_next   = step_ok ? sum_reg + SUM_W'(diff[PERIOD_W-1:0]) : sum_reg;
        count_next = step_ok ? count_reg + CNT_W'(1) : count_reg;
    end

    // Restoring divide step, quotient bit shifted in at the bottom
    always_comb
    begin
        trial     = {rem_reg, quo_reg[PERIOD_W-1]};
        fits      = (trial >= {1'b0, count_reg});
        trial_sub = trial - {1'b0, count_reg};
        rem_next  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    assign avg_final = (count_reg == '0) ? '0 : quo_reg;

    assign st.walk_done = walk_done;
    assign st.div_done  = (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // History memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hist_mem[slot_next] <= tap_time;
        end
        rd_data_reg <= hist_mem[rd_ptr_reg];
    end

    // Control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_len_reg <= AVG_LEN_RST;
            mbp_reg     <= MBP_RST;
            newest_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            age_reg     <= '0;
            walk_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            rem_reg     <= '0;
            dcnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_AVG_LEN:         avg_len_reg <= cfg_data[AVG_LEN_W-1:0];
                    REG_MAX_BEAT_PERIOD: mbp_reg     <= cfg_data[PERIOD_W-1:0];
                    default:             ;
                endcase
            end
            if (cmd.accept)
            begin
                newest_reg <= slot_next;
                rd_ptr_reg <= newest_reg;
                if (fill_reg != FW'(DEPTH))
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
                age_reg   <= CNT_W'(1);
                walk_reg  <= walk_sat;
                count_reg <= '0;
                sum_reg   <= '0;
            end
            if (cmd.issue)
            begin
                rd_ptr_reg <= rd_ptr_dec;
            end
            if (cmd.walk)
            begin
                rd_ptr_reg <= rd_ptr_dec;
                sum_reg    <= sum_next;
                count_reg  <= count_next;
                if (walk_done)
                begin
                    rem_reg  <= sum_next[SUM_W-1:PERIOD_W];
                    dcnt_reg <= '0;
                end
                else
                begin
                    age_reg <= age_reg + CNT_W'(1);
                end
            end
            if (cmd.div_step)
            begin
                rem_reg  <= rem_next;
                dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tap_reg   <= tap_time;
            newer_reg <= tap_time;
        end
        if (cmd.walk)
        begin
            newer_reg <= older;
            if (first_step)
            begin
                last_reg    <= last_calc;
                running_reg <= (older != '0) && (last_calc < TAP_W'(mbp_reg));
            end
            if (walk_done)
            begin
                quo_reg <= sum_next[PERIOD_W-1:0];
            end
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[PERIOD_W-2:0], fits};
        end
        if (cmd.load_out)
        begin
            avg_out_reg     <= avg_final;
            pvalid_out_reg  <= (avg_final != '0);
            last_out_reg    <= last_reg;
            running_out_reg <= running_reg;
            next_out_reg    <= tap_reg + TAP_W'(avg_final);
        end
    end

    assign out_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, next_out_reg, running_out_reg,
                        last_out_reg, pvalid_out_reg, avg_out_reg};

    `TTPA_ASSERT_IMPL(a_rem_bound, (cmd.div_step && count_reg != '0), (rem_reg < count_reg), "divider remainder out of range")
    `TTPA_ASSERT_IMPL(a_count_bound, 1'b1, (count_reg <= walk_reg), "more intervals counted than walked")
    `TTPA_ASSERT_NEXT(a_avg_bound, cmd.load_out, (avg_out_reg <= mbp_reg), "mean above longest beat period")

endmodule

`default_nettype wire

### rtl/tap_tempo_period_averager.sv
// ---------------------------------------------------------------------------
// tap_tempo_period_averager
// Averages the most recent tap intervals into a tempo period.
// ---------------------------------------------------------------------------
// An accepted tap passes the issue, walk, divide and done states before its
// result is loaded. The walk visits N (1 to min(avg_len, MAX_AVG), at least
// 1) history entries; the history memory delivers one older timestamp per
// cycle and the walk stops at an empty slot, an over-long interval or avg_len.
// A one-bit-per-cycle divider then forms the mean. The next tap is taken once
// the result sits in the output register, even if the sink has not taken it.
// The history is empty after reset without any clearing pass.
`default_nettype none

module tap_tempo_period_averager
    import ttpa_pkg::*;
#(
    parameter int MAX_AVG = MAX_AVG_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Tap input
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TAP_W-1:0]       s_tdata,   // [31:0] tap_time
    // Result output
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [15:0] avg_period, [16] period_valid, [48:17] last_interval,
    // [49] beat_running, [81:50] next_beat_time, [87:82] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // Configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    ttpa_cmd_t    cmd;
    ttpa_status_t st;

    ttpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ttpa_dp #(
        .MAX_AVG (MAX_AVG)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .tap_time  (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_tdata (m_tdata)
    );

endmodule

`default_nettype wire

### tb/tap_tempo_period_averager_tb.sv
// ---------------------------------------------------------------------------
// tap_tempo_period_averager_tb
// Self-checking bench: streams tap timestamps into the averager, mirrors the
// history ring and the interval walk in a local predictor, and compares every
// result beat field by field against the oldest predicted tempo result.
// Settings change only while the block is drained.
// ---------------------------------------------------------------------------
module tap_tempo_period_averager_tb;
    import ttpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH  = MAX_AVG_DEF + 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 1500;
    localparam int PHASES      = 10;
    localparam int PHASE_TAPS  = 92;
    localparam int PRINT_MAX   = 50;

    typedef struct packed {
        logic [PERIOD_W-1:0] avg_period;
        logic                period_valid;
        logic [TAP_W-1:0]    last_interval;
        logic                beat_running;
        logic [TAP_W-1:0]    next_beat_time;
    } tempo_result_t;

    // DUT ports
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TAP_W-1:0]       s_tdata   = '0;    // [31:0] tap_time
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [15:0] avg_period, [16] period_valid, [48:17] last_interval,
    // [49] beat_running, [81:50] next_beat_time, [87:82] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Bench state
    logic [TAP_W-1:0]     pending_taps[$];
    tempo_result_t        expected_tempo[$];
    logic [TAP_W-1:0]     tap_hist[HIST_DEPTH];
    int unsigned          hist_head    = 0;
    logic [AVG_LEN_W-1:0] avg_len_m    = AVG_LEN_RST;
    logic [PERIOD_W-1:0]  max_period_m = MBP_RST;
    logic                 calm_phase   = 1'b0;
    int unsigned          taps_sent    = 0;
    int unsigned          src_gap      = 0;
    int unsigned          sink_gap     = 0;
    int unsigned          sink_hold    = 0;
    logic                 hold_done    = 1'b0;
    int unsigned          err_cnt      = 0;
    int unsigned          cycle_cnt    = 0;

    tap_tempo_period_averager i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned draw_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Push the tap into the history ring and walk the recent intervals
    function automatic tempo_result_t predict_tempo(logic [TAP_W-1:0] tap);
        int unsigned   walk;
        int unsigned   count;
        int unsigned   k;
        logic          stopped;
        logic [63:0]   sum;
        logic [63:0]   mean;
        logic [TAP_W-1:0] older;
        logic [TAP_W-1:0] newer;
        logic [TAP_W-1:0] d;
        logic [TAP_W-1:0] prev;
        tempo_result_t r;
        walk = (avg_len_m > MAX_AVG_DEF) ? MAX_AVG_DEF : avg_len_m;
        hist_head = (hist_head + 1) % HIST_DEPTH;
        tap_hist[hist_head] = tap;
        sum = '0;
        count = 0;
        stopped = 1'b0;
        for (k = 1; k <= walk; k++)
        begin
            if (!stopped)
            begin
                older = tap_hist[(hist_head + HIST_DEPTH - k) % HIST_DEPTH];
                newer = tap_hist[(hist_head + HIST_DEPTH - k + 1) % HIST_DEPTH];
                d = newer - older;
                if (older == '0 || d > {16'h0, max_period_m})
                    stopped = 1'b1;
                else
                begin
                    sum += {32'h0, d};
                    count++;
                end
            end
        end
        mean = (count != 0) ? sum / count : 64'h0;
        prev = tap_hist[(hist_head + HIST_DEPTH - 1) % HIST_DEPTH];
        r.avg_period     = mean[PERIOD_W-1:0];
        r.period_valid   = (r.avg_period != '0);
        r.last_interval  = tap - prev;
        r.beat_running   = (prev != '0) && (r.last_interval < {16'h0, max_period_m});
        r.next_beat_time = tap + {16'h0, r.avg_period};
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (err_cnt < PRINT_MAX)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Source driver: predict on each accepted beat, then offer the next tap
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_tempo.push_back(predict_tempo(s_tdata));
                taps_sent <= taps_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_taps.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_taps.pop_front();
                    src_gap  <= draw_idle();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // One long sink hold-off while the source keeps offering taps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sink_hold > 0)
                sink_hold <= sink_hold - 1;
            else if (!hold_done && taps_sent == HOLD_AT)
            begin
                sink_hold <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // Result monitor and sink backpressure
    always @(posedge clk)
    begin
        tempo_result_t got;
        tempo_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.avg_period     = m_tdata[15:0];
                got.period_valid   = m_tdata[16];
                got.last_interval  = m_tdata[48:17];
                got.beat_running   = m_tdata[49];
                got.next_beat_time = m_tdata[81:50];
                if (expected_tempo.size() == 0)
                    report_mismatch($sformatf("result beat with nothing expected: %h", m_tdata));
                else
                begin
                    want = expected_tempo.pop_front();
                    if (got.avg_period !== want.avg_period)
                        report_mismatch($sformatf("avg_period exp %0d got %0d",
                                                  want.avg_period, got.avg_period));
                    if (got.period_valid !== want.period_valid)
                        report_mismatch($sformatf("period_valid exp %0b got %0b",
                                                  want.period_valid, got.period_valid));
                    if (got.last_interval !== want.last_interval)
                        report_mismatch($sformatf("last_interval exp %h got %h",
                                                  want.last_interval, got.last_interval));
                    if (got.beat_running !== want.beat_running)
                        report_mismatch($sformatf("beat_running exp %0b got %0b",
                                                  want.beat_running, got.beat_running));
                    if (got.next_beat_time !== want.next_beat_time)
                        report_mismatch($sformatf("next_beat_time exp %h got %h",
                                                  want.next_beat_time, got.next_beat_time));
                end
            end
            if (sink_hold > 0)
                m_tready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_gap <= draw_idle();
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == REG_AVG_LEN)
            avg_len_m = val[AVG_LEN_W-1:0];
        else
            max_period_m = val;
    endtask

    // Wait until every tap is taken and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_taps.size() != 0 || s_tvalid || expected_tempo.size() != 0);
    endtask

    // Random taps: mostly beat trains within max_beat_period, some noise
    task automatic queue_random_taps(int unsigned n);
        logic [TAP_W-1:0] cur;
        int unsigned      i;
        int unsigned      r;
        cur = $urandom;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 76)
                cur = cur + $urandom_range(0, max_period_m);
            else if (r < 81)
                cur = cur + max_period_m;
            else if (r < 88)
                cur = cur + max_period_m + 1 + $urandom_range(0, 100000);
            else if (r < 92)
                cur = cur - $urandom_range(1, 1 << 20);
            else if (r < 96)
                cur = '0;
            else
                cur = $urandom;
            pending_taps.push_back(cur);
        end
    endtask

    // Stimulus sequencer
    initial
    begin
        int unsigned      ph;
        int unsigned      k;
        logic [6:0]       len_sel;
        logic [15:0]      per_sel;
        logic [TAP_W-1:0] t;
        for (k = 0; k < HIST_DEPTH; k++)
            tap_hist[k] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed at reset settings: empty history, exact limit, wrap,
        // backward step, zero-length interval, zero tap
        pending_taps.push_back(32'h0000_0000);
        pending_taps.push_back(32'd1000);
        pending_taps.push_back(32'd1500);
        pending_taps.push_back(32'hFFFF_FFFF);
        pending_taps.push_back(32'd999);
        pending_taps.push_back(32'd3499);
        pending_taps.push_back(32'd6000);
        pending_taps.push_back(32'd6000);
        pending_taps.push_back(32'd5000);
        pending_taps.push_back(32'h0000_0000);
        pending_taps.push_back(32'd700);
        pending_taps.push_back(32'hAAAA_AAAA);
        wait_drained();

        for (ph = 0; ph < PHASES; ph++)
        begin
            calm_phase = (ph == 2 || ph == 7);
            case (ph)
                0: begin len_sel = 7'd64;  per_sel = 16'd65535; end
                1: begin len_sel = 7'd0;   per_sel = 16'd3000;  end
                2: begin len_sel = 7'd127; per_sel = 16'd1000;  end
                3: begin len_sel = 7'd65;  per_sel = 16'd500;   end
                4: begin len_sel = 7'd1;   per_sel = 16'd1;     end
                5: begin len_sel = 7'd16;  per_sel = 16'd0;     end
                6: begin len_sel = 7'd64;  per_sel = 16'd2500;  end
                7: begin len_sel = 7'd8;   per_sel = 16'($urandom_range(1, 65535)); end
                8: begin len_sel = 7'($urandom_range(1, 64));
                         per_sel = 16'($urandom_range(1, 65535)); end
                default: begin len_sel = 7'($urandom_range(0, 127));
                         per_sel = 16'($urandom); end
            endcase
            write_reg(REG_AVG_LEN, {9'h0, len_sel});
            write_reg(REG_MAX_BEAT_PERIOD, per_sel);
            @(negedge clk);
            // Longest intervals that still count, ending just below 2^32
            if (ph == 0)
            begin
                t = 32'hFFF0_0000;
                for (k = 0; k < 13; k++)
                begin
                    pending_taps.push_back(t);
                    t = t + 32'd65535;
                end
            end
            queue_random_taps(PHASE_TAPS);
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
